@@ src/largest_items_tracker_defines.svh @@
// assertion macros shared by the tracker modules
`ifndef LARGEST_ITEMS_TRACKER_DEFINES_SVH
`define LARGEST_ITEMS_TRACKER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked on every rising clock edge outside reset
`define CHECK_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define CHECK_IMPLY(label, ante, cons, msg)
`define CHECK_NEXT(label, ante, cons, msg)
`endif

`endif

@@ src/lit_pkg.sv @@
// shared types and constants of the largest items tracker
package lit_pkg;

   localparam int FUNC_W  = 2;
   localparam int SIZE_W  = 48;
   localparam int TAG_W   = 20;
   localparam int RANK_W  = 10;
   localparam int HELD_W  = 11;
   localparam int COUNT_W = 32;
   localparam int BYTES_W = 56;
   localparam int ENTRY_W = SIZE_W + TAG_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD_FILE   = 2'd0,
      FUNC_ADD_FOLDER = 2'd1,
      FUNC_READ       = 2'd2,
      FUNC_CLEAR      = 2'd3
   } func_type;

   // controller to datapath
   typedef struct packed {
      logic capture;      // latch request, update counters
      logic rd_rank;      // read ram at requested rank
      logic rd_prev;      // read ram at scan index minus one
      logic wr_new;       // write new entry at scan index
      logic wr_shift;     // move read entry down to scan index
      logic dec_idx;      // step scan index up the list
      logic held_inc;     // entry inserted, list grows unless full
      logic latch_entry;  // capture ram data as read result
      logic emit;         // load result registers, raise strobe
   } lit_cmd_type;

   // datapath to controller
   typedef struct packed {
      func_type func;
      logic     full;
      logic     idx_zero;
      logic     greater;   // ram entry size above new size
      logic     rank_ok;
   } lit_status_type;

endpackage

@@ src/largest_items_tracker.sv @@
// largest items tracker: ranked list of the biggest files plus counters
// accept to strobe: folder, clear and a read past the list pass capture, dispatch and response;
// a read inside the list adds a ram read wait state; a file add on a full list first checks
// the smallest entry, drops a smaller file, and otherwise scans up from the tail, moving entries down
// busy holds off the next request until the strobe cycle, so requests never overlap
// sync active-high reset empties the list and zeroes counters; receiver cannot stall
`include "largest_items_tracker_defines.svh"

module largest_items_tracker #(
   parameter int TOP_COUNT = 500
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [lit_pkg::FUNC_W-1:0]    req_func,
   input  logic [lit_pkg::SIZE_W-1:0]    req_file_size,
   input  logic [lit_pkg::TAG_W-1:0]     req_file_tag,
   input  logic [lit_pkg::RANK_W-1:0]    req_rank,
   // result channel
   output logic                          rsp_strobe,
   output logic                          rsp_entry_valid,
   output logic [lit_pkg::SIZE_W-1:0]    rsp_entry_size,
   output logic [lit_pkg::TAG_W-1:0]     rsp_entry_tag,
   output logic [lit_pkg::HELD_W-1:0]    rsp_entries_held,
   output logic [lit_pkg::COUNT_W-1:0]   rsp_file_count,
   output logic [lit_pkg::COUNT_W-1:0]   rsp_folder_count,
   output logic [lit_pkg::BYTES_W-1:0]   rsp_total_bytes
);
   import lit_pkg::*;

   lit_cmd_type    cmd;
   lit_status_type status;
   func_type       func;

   // request function code as its enum
   assign func = func_type'(req_func);

   // sequencer: capture, insertion scan from the tail upward, rank read
   lit_controller u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // counters, ranked list ram and result registers
   lit_datapath #(
      .TOP_COUNT (TOP_COUNT)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_func         (func),
      .req_file_size    (req_file_size),
      .req_file_tag     (req_file_tag),
      .req_rank         (req_rank),
      .rsp_strobe       (rsp_strobe),
      .rsp_entry_valid  (rsp_entry_valid),
      .rsp_entry_size   (rsp_entry_size),
      .rsp_entry_tag    (rsp_entry_tag),
      .rsp_entries_held (rsp_entries_held),
      .rsp_file_count   (rsp_file_count),
      .rsp_folder_count (rsp_folder_count),
      .rsp_total_bytes  (rsp_total_bytes)
   );

   // every request path passes through the capture, dispatch and response states, so strobes never abut
   `CHECK_NEXT(a_strobe_single, rsp_strobe, !rsp_strobe, "result strobe held two cycles")
   // a result only goes out while busy is low, save where $past(start) was set
   `CHECK_IMPLY(a_strobe_idle, rsp_strobe, !busy || $past(start), "strobe while still working")

endmodule

@@ src/lit_ram.sv @@
// generic single write port, single read port ram with registered read
module lit_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ src/lit_datapath.sv @@
// counters, ranked list storage and result registers of the tracker
`include "largest_items_tracker_defines.svh"

module lit_datapath #(
   parameter int TOP_COUNT = 500
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lit_pkg::lit_cmd_type              cmd,
   output lit_pkg::lit_status_type           status,
   input  lit_pkg::func_type                 req_func,
   input  logic [lit_pkg::SIZE_W-1:0]        req_file_size,
   input  logic [lit_pkg::TAG_W-1:0]         req_file_tag,
   input  logic [lit_pkg::RANK_W-1:0]        req_rank,
   output logic                              rsp_strobe,
   output logic                              rsp_entry_valid,
   output logic [lit_pkg::SIZE_W-1:0]        rsp_entry_size,
   output logic [lit_pkg::TAG_W-1:0]         rsp_entry_tag,
   output logic [lit_pkg::HELD_W-1:0]        rsp_entries_held,
   output logic [lit_pkg::COUNT_W-1:0]       rsp_file_count,
   output logic [lit_pkg::COUNT_W-1:0]       rsp_folder_count,
   output logic [lit_pkg::BYTES_W-1:0]       rsp_total_bytes
);
   import lit_pkg::*;

   localparam int AW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;
   localparam int CW = $clog2(TOP_COUNT + 1);

   func_type            func_ff;
   logic [SIZE_W-1:0]   size_ff;
   logic [TAG_W-1:0]    tag_ff;
   logic [RANK_W-1:0]   rank_ff;
   logic [AW-1:0]       idx_ff;
   logic [CW-1:0]       held_ff;
   logic [COUNT_W-1:0]  files_ff;
   logic [COUNT_W-1:0]  folders_ff;
   logic [BYTES_W-1:0]  bytes_ff;
   logic                entry_valid_ff;
   logic [SIZE_W-1:0]   entry_size_ff;
   logic [TAG_W-1:0]    entry_tag_ff;

   logic                rsp_strobe_ff;
   logic                rsp_entry_valid_ff;
   logic [SIZE_W-1:0]   rsp_entry_size_ff;
   logic [TAG_W-1:0]    rsp_entry_tag_ff;
   logic [HELD_W-1:0]   rsp_entries_held_ff;
   logic [COUNT_W-1:0]  rsp_file_count_ff;
   logic [COUNT_W-1:0]  rsp_folder_count_ff;
   logic [BYTES_W-1:0]  rsp_total_bytes_ff;

   logic                full;
   logic [BYTES_W:0]    bytes_sum;
   logic                ram_we;
   logic [AW-1:0]       ram_raddr;
   logic [ENTRY_W-1:0]  ram_wdata;
   logic [ENTRY_W-1:0]  ram_rdata;

   assign full      = (held_ff == CW'(TOP_COUNT));
   assign bytes_sum = {1'b0, bytes_ff} + (BYTES_W + 1)'(req_file_size);

   assign ram_we    = cmd.wr_new | cmd.wr_shift;
   assign ram_wdata = cmd.wr_new ? {size_ff, tag_ff} : ram_rdata;

   always_comb begin
      if (cmd.rd_rank) begin
         ram_raddr = rank_ff[AW-1:0];
      end else if (cmd.rd_prev) begin
         ram_raddr = idx_ff - AW'(1);
      end else begin
         ram_raddr = idx_ff;
      end
   end

   lit_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TOP_COUNT)
   ) u_ranked (
      .clock (clock),
      .we    (ram_we),
      .waddr (idx_ff),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign status.func     = func_ff;
   assign status.full     = full;
   assign status.idx_zero = (idx_ff == '0);
   assign status.greater  = (ram_rdata[ENTRY_W-1:TAG_W] > size_ff);
   assign status.rank_ok  = (HELD_W'(rank_ff) < HELD_W'(held_ff));

   // request payload and scan index
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff <= req_func;
         size_ff <= req_file_size;
         tag_ff  <= req_file_tag;
         rank_ff <= req_rank;
         idx_ff  <= full ? AW'(TOP_COUNT - 1) : held_ff[AW-1:0];
      end else if (cmd.dec_idx) begin
         idx_ff  <= idx_ff - AW'(1);
      end
   end

   // saturating counters and list length
   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         files_ff   <= '0;
         folders_ff <= '0;
         bytes_ff   <= '0;
      end else if (cmd.capture) begin
         case (req_func)
            FUNC_ADD_FILE: begin
               if (files_ff != '1) begin
                  files_ff <= files_ff + COUNT_W'(1);
               end
               bytes_ff <= bytes_sum[BYTES_W] ? '1 : bytes_sum[BYTES_W-1:0];
            end
            FUNC_ADD_FOLDER: begin
               if (folders_ff != '1) begin
                  folders_ff <= folders_ff + COUNT_W'(1);
               end
            end
            FUNC_CLEAR: begin
               held_ff    <= '0;
               files_ff   <= '0;
               folders_ff <= '0;
               bytes_ff   <= '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.held_inc && !full) begin
         held_ff <= held_ff + CW'(1);
      end
   end

   // entry fields of a read
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         entry_valid_ff <= 1'b0;
         entry_size_ff  <= '0;
         entry_tag_ff   <= '0;
      end else if (cmd.latch_entry) begin
         entry_valid_ff <= 1'b1;
         entry_size_ff  <= ram_rdata[ENTRY_W-1:TAG_W];
         entry_tag_ff   <= ram_rdata[TAG_W-1:0];
      end
   end

   // result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
      end
      if (cmd.emit) begin
         rsp_entry_valid_ff  <= entry_valid_ff;
         rsp_entry_size_ff   <= entry_size_ff;
         rsp_entry_tag_ff    <= entry_tag_ff;
         rsp_entries_held_ff <= HELD_W'(held_ff);
         rsp_file_count_ff   <= files_ff;
         rsp_folder_count_ff <= folders_ff;
         rsp_total_bytes_ff  <= bytes_ff;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_entry_valid  = rsp_entry_valid_ff;
   assign rsp_entry_size   = rsp_entry_size_ff;
   assign rsp_entry_tag    = rsp_entry_tag_ff;
   assign rsp_entries_held = rsp_entries_held_ff;
   assign rsp_file_count   = rsp_file_count_ff;
   assign rsp_folder_count = rsp_folder_count_ff;
   assign rsp_total_bytes  = rsp_total_bytes_ff;

   `CHECK_IMPLY(a_held_bound, 1'b1, held_ff <= CW'(TOP_COUNT), "list length above capacity")
   `CHECK_NEXT(a_grow_one, cmd.held_inc && !full, held_ff == $past(held_ff) + CW'(1), "list did not grow by one")

endmodule

@@ src/lit_controller.sv @@
// sequencer for capture, insertion scan, rank read and result strobe
`include "largest_items_tracker_defines.svh"

module lit_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  lit_pkg::lit_status_type status,
   output lit_pkg::lit_cmd_type    cmd
);
   import lit_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FULL_CHK,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      busy_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.func)
               FUNC_ADD_FILE: begin
                  // full list: look at the smallest entry first
                  state_in = status.full ? ST_FULL_CHK : ST_SCAN_RD;
               end
               FUNC_READ: begin
                  if (status.rank_ok) begin
                     cmd.rd_rank = 1'b1;
                     state_in    = ST_READ_WAIT;
                  end else begin
                     state_in = ST_RESP;
                  end
               end
               default: begin
                  state_in = ST_RESP;
               end
            endcase
         end
         ST_FULL_CHK: begin
            // new item smaller than the smallest held one is dropped
            state_in = status.greater ? ST_RESP : ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            if (status.idx_zero) begin
               cmd.wr_new   = 1'b1;
               cmd.held_inc = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.rd_prev = 1'b1;
               state_in    = ST_SCAN_CMP;
            end
         end
         ST_SCAN_CMP: begin
            if (status.greater) begin
               cmd.wr_new   = 1'b1;
               cmd.held_inc = 1'b1;
               state_in     = ST_RESP;
            end else begin
               cmd.wr_shift = 1'b1;
               cmd.dec_idx  = 1'b1;
               state_in     = ST_SCAN_RD;
            end
         end
         ST_READ_WAIT: begin
            cmd.latch_entry = 1'b1;
            state_in        = ST_RESP;
         end
         ST_RESP: begin
            cmd.emit = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

   `CHECK_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
   `CHECK_IMPLY(a_no_write_on_read, status.func == FUNC_READ && !busy_ff == 1'b0 && (cmd.wr_new || cmd.wr_shift), status.func != FUNC_READ, "list written during a read")

endmodule
